// File: rtl/ftk_pkg.sv
`default_nettype none

package ftk_pkg;

  // Fixed field widths of the cell and result items.
  localparam int ID_W     = 16;
  localparam int COORD_W  = 16;
  localparam int CENTER_W = 21;
  localparam int DIST_W   = 44;
  localparam int RANK_W   = 4;
  localparam int LCOUNT_W = 5;

  // At most this many results leave the block per run.
  localparam int MAX_EMIT = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Defaults of the top-level parameters.
  localparam int LIST_DEPTH_DEF = 16;
  localparam int CELL_LOG2_DEF  = 5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;

  // Axis counter of the distance unit: x, y, then z.
  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_MID   = 2'd1;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   cell_id;
    logic [DIST_W-1:0] dist_sq;
  } list_entry_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_DIFF,
    D_MUL,
    D_ACC
  } dist_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_FULL_RD,
    S_FULL_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_EMIT_RD,
    S_EMIT_OUT
  } list_state_e;

endpackage

`default_nettype wire

// File: rtl/ftk_ram.sv
`default_nettype none

module ftk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/ftk_dist_unit.sv
`default_nettype none

module ftk_dist_unit
  import ftk_pkg::*;
#(
  parameter int CELL_LOG2 = CELL_LOG2_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [COORD_W-1:0]  cell_x_i,
  input  wire logic signed [COORD_W-1:0]  cell_y_i,
  input  wire logic signed [COORD_W-1:0]  cell_z_i,
  input  wire logic signed [CENTER_W-1:0] center_x_i,
  input  wire logic signed [CENTER_W-1:0] center_y_i,
  input  wire logic signed [CENTER_W-1:0] center_z_i,
  output logic                            done_o,
  output logic             [DIST_W-1:0]   dist_o
);

  localparam int P_W     = COORD_W + CELL_LOG2;
  localparam int D_W     = (P_W > CENTER_W ? P_W : CENTER_W) + 1;
  localparam int A_W     = D_W;
  localparam int SQ_W    = 2 * A_W;
  localparam int ACC_W   = SQ_W + 2;
  localparam int HALF_M1 = (1 << (CELL_LOG2 - 1)) - 1;

  dist_state_e state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic              done_q, done_d;
  logic [A_W-1:0]    abs_q, abs_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [ACC_W-1:0]  acc_q, acc_d, acc_sum;
  logic [DIST_W-1:0] dist_q, dist_d;

  logic signed [COORD_W-1:0]  cell_sel;
  logic signed [CENTER_W-1:0] cen_sel;
  logic signed [P_W-1:0]      centre_pt;
  logic signed [D_W-1:0]      diff;

  always_comb begin
    case (axis_q)
      AXIS_FIRST: begin
        cell_sel = cell_x_i;
        cen_sel  = center_x_i;
      end
      AXIS_MID: begin
        cell_sel = cell_y_i;
        cen_sel  = center_y_i;
      end
      default: begin
        cell_sel = cell_z_i;
        cen_sel  = center_z_i;
      end
    endcase
  end

  // Cell centre in fine units, then its offset from the reference point.
  assign centre_pt = (P_W'(cell_sel) <<< CELL_LOG2) + P_W'(HALF_M1);
  assign diff      = D_W'(centre_pt) - D_W'(cen_sel);
  assign acc_sum   = acc_q + ACC_W'(sq_q);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    done_d  = 1'b0;
    abs_d   = abs_q;
    sq_d    = sq_q;
    acc_d   = acc_q;
    dist_d  = dist_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          axis_d  = AXIS_FIRST;
          acc_d   = '0;
          state_d = D_DIFF;
        end
      end
      D_DIFF: begin
        abs_d   = diff[D_W-1] ? A_W'(-diff) : A_W'(diff);
        state_d = D_MUL;
      end
      D_MUL: begin
        sq_d    = SQ_W'(abs_q) * SQ_W'(abs_q);
        state_d = D_ACC;
      end
      D_ACC: begin
        acc_d = acc_sum;
        if (axis_q == AXIS_LAST) begin
          dist_d  = (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = D_DIFF;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      axis_q  <= AXIS_FIRST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q  <= abs_d;
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    dist_q <= dist_d;
  end

  assign done_o = done_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// File: rtl/farthest_k_sorted_insert_top.sv
// Each item first gets its distance (three axes of difference, square and accumulate on one
// shared multiplier), then walks back through the list entries that it moves past.
// Items are taken one at a time; the input stalls until the item's insertion and output run end.
// An end-of-pass item then reads its results out one by one through the list RAM's
// single registered read port. Reset (rst_ni, asynchronous, active low) empties the list
// and clears the reference point; list contents need no clearing pass.
`default_nettype none

module farthest_k_sorted_insert_top
  import ftk_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int CELL_LOG2  = CELL_LOG2_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration port.
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CENTER_W-1:0]        cfg_wdata_i,
  // Input channel.
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ID_W-1:0]            cell_id_i,
  input  wire logic signed [COORD_W-1:0]  cell_x_i,
  input  wire logic signed [COORD_W-1:0]  cell_y_i,
  input  wire logic signed [COORD_W-1:0]  cell_z_i,
  input  wire logic                       end_of_pass_i,
  // Output channel.
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            entry_valid_o,
  output logic [RANK_W-1:0]               rank_o,
  output logic [ID_W-1:0]                 out_cell_id_o,
  output logic [DIST_W-1:0]               distance_sq_o,
  output logic [LCOUNT_W-1:0]             list_count_o,
  output logic                            last_of_run_o
);

  localparam int IDX_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int EMIT_LIM = (LIST_DEPTH < MAX_EMIT) ? LIST_DEPTH : MAX_EMIT;

  // The user writes the reference point via the configuration port while idle; not enforced.
  logic signed [CENTER_W-1:0] center_x_q, center_y_q, center_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_wdata_i;
        REG_CENTER_Y: center_y_q <= cfg_wdata_i;
        REG_CENTER_Z: center_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The accepted item is held here for the whole of its processing.
  logic [ID_W-1:0]           id_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic                      eop_q;

  list_state_e state_q, state_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic              dist_start;
  logic              dist_done;
  logic [DIST_W-1:0] new_dist;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  list_entry_t      ram_wdata, ram_rdata, new_entry;

  logic              out_valid_q, out_valid_d;
  logic              entry_valid_q, entry_valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [ID_W-1:0]   ocell_q, ocell_d;
  logic [DIST_W-1:0] odist_q, odist_d;
  logic [LCOUNT_W-1:0] ocount_q, ocount_d;
  logic              olast_q, olast_d;

  logic             accept;
  logic             list_full;
  logic             out_free;
  logic [CNT_W-1:0] emit_n;
  logic             emit_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign dist_start = accept;
  assign list_full  = (count_q == CNT_W'(LIST_DEPTH));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_n     = (count_q > CNT_W'(EMIT_LIM)) ? CNT_W'(EMIT_LIM) : count_q;
  assign emit_last  = (CNT_W'(k_q) + CNT_W'(1)) == emit_n;
  assign new_entry  = '{cell_id: id_q, dist_sq: new_dist};

  // One shared multiplier works through the three axes in turn.
  ftk_dist_unit #(
    .CELL_LOG2(CELL_LOG2)
  ) u_dist (
    .clk_i,
    .rst_ni,
    .start_i   (dist_start),
    .cell_x_i  (accept ? cell_x_i : x_q),
    .cell_y_i  (accept ? cell_y_i : y_q),
    .cell_z_i  (accept ? cell_z_i : z_q),
    .center_x_i(center_x_q),
    .center_y_i(center_y_q),
    .center_z_i(center_z_q),
    .done_o    (dist_done),
    .dist_o    (new_dist)
  );

  // The sorted list, farthest first, in a RAM with one registered read port.
  ftk_ram #(
    .WIDTH($bits(list_entry_t)),
    .DEPTH(LIST_DEPTH)
  ) u_list (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Insertion walks backwards from the end of the list: every entry strictly nearer than
  // the newcomer moves down one place, and the newcomer lands behind the first entry that
  // is at least as far away, so ties keep their arrival order. When the list is full, the
  // last entry is checked first: if it is at least as far, the newcomer is dropped.
  always_comb begin
    state_d       = state_q;
    j_d           = j_q;
    k_d           = k_q;
    count_d       = count_q;
    ram_we        = 1'b0;
    ram_waddr     = j_q;
    ram_wdata     = new_entry;
    ram_raddr     = IDX_W'(j_q - 1'b1);
    out_valid_d   = out_valid_q && out_stall_i;
    entry_valid_d = entry_valid_q;
    rank_d        = rank_q;
    ocell_d       = ocell_q;
    odist_d       = odist_q;
    ocount_d      = ocount_q;
    olast_d       = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        if (dist_done) begin
          if (list_full) begin
            state_d = S_FULL_RD;
          end else begin
            j_d     = IDX_W'(count_q);
            state_d = S_INS_RD;
          end
        end
      end
      S_FULL_RD: begin
        ram_raddr = IDX_W'(LIST_DEPTH - 1);
        state_d   = S_FULL_CHK;
      end
      S_FULL_CHK: begin
        if (ram_rdata.dist_sq >= new_dist) begin
          state_d = eop_q ? S_EMIT_RD : S_IDLE;
          k_d     = '0;
        end else begin
          j_d     = IDX_W'(LIST_DEPTH - 1);
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (j_q == '0) begin
          ram_we  = 1'b1;
          count_d = list_full ? count_q : count_q + CNT_W'(1);
          k_d     = '0;
          state_d = eop_q ? S_EMIT_RD : S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.dist_sq < new_dist) begin
          ram_wdata = ram_rdata;
          j_d       = IDX_W'(j_q - 1'b1);
          state_d   = S_INS_RD;
        end else begin
          count_d = list_full ? count_q : count_q + CNT_W'(1);
          k_d     = '0;
          state_d = eop_q ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        // Read the next entry; move on once the output register is free or being taken.
        ram_raddr = k_q;
        if (out_free) begin
          if (count_q == '0) begin
            out_valid_d   = 1'b1;
            entry_valid_d = 1'b0;
            rank_d        = '0;
            ocell_d       = '0;
            odist_d       = '0;
            ocount_d      = '0;
            olast_d       = 1'b1;
            state_d       = S_IDLE;
          end else begin
            state_d = S_EMIT_OUT;
          end
        end
      end
      S_EMIT_OUT: begin
        out_valid_d   = 1'b1;
        entry_valid_d = 1'b1;
        rank_d        = RANK_W'(k_q);
        ocell_d       = ram_rdata.cell_id;
        odist_d       = ram_rdata.dist_sq;
        ocount_d      = LCOUNT_W'(count_q);
        olast_d       = emit_last;
        if (emit_last) begin
          count_d = '0;
          state_d = S_IDLE;
        end else begin
          k_d     = IDX_W'(k_q + 1'b1);
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q  <= cell_id_i;
      x_q   <= cell_x_i;
      y_q   <= cell_y_i;
      z_q   <= cell_z_i;
      eop_q <= end_of_pass_i;
    end
    j_q           <= j_d;
    k_q           <= k_d;
    entry_valid_q <= entry_valid_d;
    rank_q        <= rank_d;
    ocell_q       <= ocell_d;
    odist_q       <= odist_d;
    ocount_q      <= ocount_d;
    olast_q       <= olast_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_valid_o = entry_valid_q;
  assign rank_o        = rank_q;
  assign out_cell_id_o = ocell_q;
  assign distance_sq_o = odist_q;
  assign list_count_o  = ocount_q;
  assign last_of_run_o = olast_q;

endmodule

`default_nettype wire

// File: rtl/ftk_checker.sv
`default_nettype none

module ftk_checker
  import ftk_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                entry_valid_o,
  input wire logic [RANK_W-1:0]   rank_o,
  input wire logic [ID_W-1:0]     out_cell_id_o,
  input wire logic [DIST_W-1:0]   distance_sq_o,
  input wire logic [LCOUNT_W-1:0] list_count_o,
  input wire logic                last_of_run_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_cell_id_o)
      && $stable(distance_sq_o) && $stable(rank_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // An accepted item stalls the input straight after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after an item");

  // The empty-list marker is a one-result run carrying no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_of_run_o && list_count_o == '0
      && rank_o == '0)
    else $error("malformed empty-list result");

  // On a shallow list the run ends at the entry whose rank closes the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LIST_DEPTH <= MAX_EMIT) && out_valid_o && entry_valid_o
      |-> ((LCOUNT_W'(rank_o) + LCOUNT_W'(1) == list_count_o) == last_of_run_o))
    else $error("run end does not match list count");

endmodule

bind farthest_k_sorted_insert_top ftk_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_ftk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .entry_valid_o(entry_valid_o),
  .rank_o       (rank_o),
  .out_cell_id_o(out_cell_id_o),
  .distance_sq_o(distance_sq_o),
  .list_count_o (list_count_o),
  .last_of_run_o(last_of_run_o)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the farthest-K sorted insertion block.
// Every accepted cell item is fed to a predictor that keeps its own copy of the
// reference point and of the sorted list. Each end-of-pass item queues the
// expected output run, and the output monitor compares every accepted result
// against the oldest queued entry, field by field.
module tb;
  import ftk_pkg::*;

  // Index 3 has no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [CENTER_W-1:0] CENTRE_MAX = 21'h0F_FFFF;
  localparam logic [CENTER_W-1:0] CENTRE_MIN = 21'h10_0000;

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 226;
  // The last stretch of the run goes without any idling on either side.
  localparam int CALM_MARK      = DIRECTED_ITEMS + RANDOM_ITEMS - 40;
  // Long enough to cover an item still in flight, through its distance and
  // a full walk of the list.
  localparam int SETTLE_CYCLES  = 100;
  localparam int LIMIT_CYCLES   = 400_000;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      eop;
  } cell_item_t;

  typedef struct packed {
    logic                entry_valid;
    logic [RANK_W-1:0]   rank;
    logic [ID_W-1:0]     cell_id;
    logic [DIST_W-1:0]   dist_sq;
    logic [LCOUNT_W-1:0] count;
    logic                last;
  } entry_result_t;

  // Predictor and scoreboard in one: it mirrors the reference point and the
  // sorted list, and holds the results still owed by the block.
  class farthest_list_board;
    logic signed [CENTER_W-1:0] centre_x;
    logic signed [CENTER_W-1:0] centre_y;
    logic signed [CENTER_W-1:0] centre_z;
    logic [DIST_W-1:0]          held_dist [LIST_DEPTH_DEF];
    logic [ID_W-1:0]            held_cell [LIST_DEPTH_DEF];
    int                         held_count;
    entry_result_t              expected_entries [$];

    function new();
      centre_x   = '0;
      centre_y   = '0;
      centre_z   = '0;
      held_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CENTER_W-1:0] val);
      case (idx)
        REG_CENTER_X: centre_x = val;
        REG_CENTER_Y: centre_y = val;
        REG_CENTER_Z: centre_z = val;
        default: ;
      endcase
    endfunction

    // Square of the gap between the cell's centre point and the reference
    // coordinate on one axis.
    function longint axis_square(logic signed [COORD_W-1:0] coord,
                                 logic signed [CENTER_W-1:0] ctr);
      longint p;
      longint d;
      p = longint'(coord) * (longint'(1) << CELL_LOG2_DEF)
        + ((longint'(1) << CELL_LOG2_DEF) >>> 1) - 1;
      d = p - longint'(ctr);
      if (d < 0) d = -d;
      return d * d;
    endfunction

    function logic [DIST_W-1:0] cell_distance_sq(cell_item_t c);
      longint s;
      s = axis_square(c.x, centre_x) + axis_square(c.y, centre_y)
        + axis_square(c.z, centre_z);
      if (s > longint'(DIST_MAX)) s = longint'(DIST_MAX);
      return s[DIST_W-1:0];
    endfunction

    // Inserts the cell after every entry at least as far, then on an end-of-pass
    // item queues the whole list (or the empty-list marker) and empties it.
    function void note_cell(cell_item_t c);
      logic [DIST_W-1:0] d;
      int                pos;
      int                n;
      entry_result_t     r;
      d   = cell_distance_sq(c);
      pos = 0;
      while (pos < held_count && held_dist[pos] >= d) pos++;
      if (pos < LIST_DEPTH_DEF) begin
        for (int j = LIST_DEPTH_DEF - 1; j > pos; j--) begin
          held_dist[j] = held_dist[j-1];
          held_cell[j] = held_cell[j-1];
        end
        held_dist[pos] = d;
        held_cell[pos] = c.id;
        if (held_count < LIST_DEPTH_DEF) held_count++;
      end
      if (!c.eop) return;
      if (held_count == 0) begin
        r      = '0;
        r.last = 1'b1;
        expected_entries.push_back(r);
        return;
      end
      n = (held_count < MAX_EMIT) ? held_count : MAX_EMIT;
      for (int j = 0; j < n; j++) begin
        r.entry_valid = 1'b1;
        r.rank        = RANK_W'(j);
        r.cell_id     = held_cell[j];
        r.dist_sq     = held_dist[j];
        r.count       = LCOUNT_W'(held_count);
        r.last        = (j == n - 1);
        expected_entries.push_back(r);
      end
      held_count = 0;
    endfunction

    function bit check_entry(entry_result_t got, output string why);
      entry_result_t want;
      why = "";
      if (expected_entries.size() == 0) begin
        why = $sformatf("result id %0h arrived with nothing expected", got.cell_id);
        return 1'b0;
      end
      want = expected_entries.pop_front();
      if (got.entry_valid !== want.entry_valid)
        why = {why, $sformatf(" entry_valid %b want %b", got.entry_valid, want.entry_valid)};
      if (got.rank !== want.rank)
        why = {why, $sformatf(" rank %0d want %0d", got.rank, want.rank)};
      if (got.cell_id !== want.cell_id)
        why = {why, $sformatf(" cell_id %h want %h", got.cell_id, want.cell_id)};
      if (got.dist_sq !== want.dist_sq)
        why = {why, $sformatf(" distance_sq %0d want %0d", got.dist_sq, want.dist_sq)};
      if (got.count !== want.count)
        why = {why, $sformatf(" list_count %0d want %0d", got.count, want.count)};
      if (got.last !== want.last)
        why = {why, $sformatf(" last_of_run %b want %b", got.last, want.last)};
      if (why != "") why = {$sformatf("rank %0d:", want.rank), why};
      return why == "";
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [CENTER_W-1:0]        cfg_wdata_i   = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [ID_W-1:0]            cell_id_i     = '0;
  logic signed [COORD_W-1:0]  cell_x_i      = '0;
  logic signed [COORD_W-1:0]  cell_y_i      = '0;
  logic signed [COORD_W-1:0]  cell_z_i      = '0;
  logic                       end_of_pass_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic                       entry_valid_o;
  logic [RANK_W-1:0]          rank_o;
  logic [ID_W-1:0]            out_cell_id_o;
  logic [DIST_W-1:0]          distance_sq_o;
  logic [LCOUNT_W-1:0]        list_count_o;
  logic                       last_of_run_o;

  farthest_list_board  board;
  int                  mismatches   = 0;
  int                  sent         = 0;
  int                  cycle_count  = 0;
  int                  in_idle_pct  = 0;
  int                  out_idle_pct = 0;
  int                  stall_left   = 0;
  bit                  calm         = 1'b0;
  cell_item_t          last_cell    = '0;
  logic [CENTER_W-1:0] reg_plan [4];

  farthest_k_sorted_insert_top #(
    .LIST_DEPTH (LIST_DEPTH_DEF),
    .CELL_LOG2  (CELL_LOG2_DEF)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_id_i     (cell_id_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .end_of_pass_i (end_of_pass_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_valid_o (entry_valid_o),
    .rank_o        (rank_o),
    .out_cell_id_o (out_cell_id_o),
    .distance_sq_o (distance_sq_o),
    .list_count_o  (list_count_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Output side. The monitor samples at the edge, before any update from the
  // same edge lands, and then decides the stall for the coming cycle. Stalls come in bursts.
  always @(posedge clk_i) begin
    entry_result_t got;
    string         why;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.entry_valid = entry_valid_o;
      got.rank        = rank_o;
      got.cell_id     = out_cell_id_o;
      got.dist_sq     = distance_sq_o;
      got.count       = list_count_o;
      got.last        = last_of_run_o;
      if (!board.check_entry(got, why)) report_mismatch(why);
    end
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(1, 3);
      out_stall_i <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one cell and holds it until the block takes it. Valid stays high
  // into the next item unless an idle burst is drawn, so it is never lowered
  // and raised in the same step.
  task automatic send_cell(input cell_item_t c);
    in_valid_i    <= 1'b1;
    cell_id_i     <= c.id;
    cell_x_i      <= c.x;
    cell_y_i      <= c.y;
    cell_z_i      <= c.z;
    end_of_pass_i <= c.eop;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    board.note_cell(c);
    last_cell = c;
    sent++;
    if (sent >= CALM_MARK) calm = 1'b1;
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Waits for every owed result, then lets an item that emits nothing finish
  // its walk through the list before anything else happens.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the registers picked by the mask from reg_plan, back to back, and
  // drops the write enable once at the end.
  task automatic load_registers(input logic [3:0] mask);
    for (int r = REG_CENTER_X; r <= REG_SPARE; r++) begin
      if (mask[r]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= CFG_IDX_W'(r);
        cfg_wdata_i <= reg_plan[r];
        @(posedge clk_i);
        board.set_register(CFG_IDX_W'(r), reg_plan[r]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic cell_item_t make_cell(input int id, input int x, input int y,
                                           input int z, input bit eop);
    cell_item_t c;
    c.id  = ID_W'(id);
    c.x   = COORD_W'(x);
    c.y   = COORD_W'(y);
    c.z   = COORD_W'(z);
    c.eop = eop;
    return c;
  endfunction

  // One coordinate: fully random, close to the reference point, an extreme,
  // or a copy of the previous cell so that distances tie.
  function automatic logic [COORD_W-1:0] pick_coord(input int mode,
                                                    input logic signed [CENTER_W-1:0] ctr,
                                                    input logic [COORD_W-1:0] prev);
    int t;
    case (mode)
      0, 1, 2, 3: return COORD_W'($urandom);
      4, 5: begin
        t = int'(ctr) >>> CELL_LOG2_DEF;
        return COORD_W'(t + int'($urandom_range(0, 4)) - 2);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: return COORD_W'(-32768);
          1: return COORD_W'(32767);
          2: return '0;
          default: return '1;
        endcase
      end
      default: return prev;
    endcase
  endfunction

  function automatic cell_item_t random_cell(input bit eop);
    cell_item_t c;
    int         mode;
    mode  = $urandom_range(0, 9);
    c.id  = ID_W'($urandom);
    c.x   = pick_coord(mode, board.centre_x, last_cell.x);
    c.y   = pick_coord(mode, board.centre_y, last_cell.y);
    c.z   = pick_coord(mode, board.centre_z, last_cell.z);
    c.eop = eop;
    return c;
  endfunction

  initial begin
    int phase;
    int passes;
    int len;
    int pick;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reference point still at its reset value. A lone
    // end-of-pass item at the far corner gives a one-entry run.
    send_cell(make_cell(16'hFFFF, -32768, -32768, -32768, 1'b1));
    // Three cells at the same distance, then the nearest cell: ties must keep
    // their arrival order.
    send_cell(make_cell(1, 1, 0, 0, 1'b0));
    send_cell(make_cell(2, 0, 1, 0, 1'b0));
    send_cell(make_cell(3, 0, 0, 1, 1'b0));
    send_cell(make_cell(4, 0, 0, 0, 1'b1));

    // Reference point at the top corner, then more cells than the list holds
    // so that entries drop off the end and some newcomers are discarded.
    drain_and_settle();
    reg_plan[REG_CENTER_X] = CENTRE_MAX;
    reg_plan[REG_CENTER_Y] = CENTRE_MAX;
    reg_plan[REG_CENTER_Z] = CENTRE_MAX;
    reg_plan[REG_SPARE]    = CENTER_W'($urandom);
    load_registers(4'b1111);
    for (int k = 0; k < DIRECTED_ITEMS - 6; k++)
      send_cell(make_cell(16'h0100 + k, k * 3641, -k * 3641, k * k * 97,
                          k == DIRECTED_ITEMS - 7));
    send_cell(make_cell(16'h5A5A, -32768, 32767, 0, 1'b1));

    // Random part: phases of register settings, each with a few passes.
    phase = 0;
    while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain_and_settle();
      for (int r = REG_CENTER_X; r <= REG_CENTER_Z; r++) begin
        pick = (phase == 0) ? 1 : $urandom_range(0, 5);
        case (pick)
          0: reg_plan[r] = CENTRE_MAX;
          1: reg_plan[r] = CENTRE_MIN;
          2: reg_plan[r] = '0;
          default: reg_plan[r] = CENTER_W'($urandom);
        endcase
      end
      reg_plan[REG_SPARE] = CENTER_W'($urandom);
      load_registers((phase == 0) ? 4'b0111 : 4'($urandom_range(1, 15)));
      // Some phases run with no idling at all.
      case ($urandom_range(0, 2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 15;
        default: in_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_idle_pct = 0;
        1: out_idle_pct = 15;
        default: out_idle_pct = 40;
      endcase
      passes = $urandom_range(1, 3);
      for (int p = 0; p < passes; p++) begin
        len = $urandom_range(0, 22);
        for (int i = 0; i < len; i++) send_cell(random_cell(1'b0));
        send_cell(random_cell(1'b1));
      end
      phase++;
    end

    drain_and_settle();
    if (mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: farthest_k_sorted_insert_top.f
rtl/ftk_pkg.sv
rtl/ftk_ram.sv
rtl/ftk_dist_unit.sv
rtl/farthest_k_sorted_insert_top.sv
rtl/ftk_checker.sv
tb/sv/tb.sv
